@@ rtl/scs_pkg.sv @@
// shared types and constants for the script call scanner
// no dependencies
package scs_pkg;

  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_BEGIN = 2'd1;
  localparam logic [1:0] CMD_WORD  = 2'd2;
  localparam logic [1:0] CMD_READ  = 2'd3;

  localparam logic [15:0] OPC_CALL = 16'h005C;
  localparam logic [15:0] OPC_END  = 16'h0001;
  localparam logic [15:0] OPC_MAX  = 16'h0077;

  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_TARGET = 2'd1;
  localparam logic [1:0] PH_FIRST  = 2'd2;
  localparam logic [1:0] PH_SKIP   = 2'd3;

  localparam logic [1:0] STOP_END    = 2'd0;
  localparam logic [1:0] STOP_DESYNC = 2'd1;
  localparam logic [1:0] STOP_LIMIT  = 2'd2;

  localparam logic [2:0] NO_SLOT  = 3'd7;
  localparam logic [3:0] NO_MAP   = 4'd15;
  localparam int         CTRL_IDX = 6;
  localparam int         HIT_NUM  = 7;

  localparam logic [2:0] REG_CONTROL = 3'd6;
  localparam logic [2:0] REG_LIMIT   = 3'd7;

  localparam logic [3:0] SLOT_CTRL    = 4'd6;
  localparam logic [3:0] SLOT_CAP0    = 4'd7;
  localparam logic [3:0] SLOT_CAP1    = 4'd8;
  localparam logic [3:0] SLOT_MAP     = 4'd9;
  localparam logic [3:0] SLOT_BEGUN   = 4'd10;
  localparam logic [3:0] SLOT_TRUNC   = 4'd11;

  localparam logic [12:0] LIMIT_RESET = 13'd4096;

  typedef logic [5:0][31:0] watch_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [2:0]  map_index;
    logic [31:0] script_word;
    logic [3:0]  slot;
  } item_t;

  typedef struct packed {
    logic                 clear;
    logic                 begin_walk;
    logic                 trunc;
    logic [HIT_NUM-1:0]   hit;
    logic                 cap0;
    logic                 cap1;
    logic [31:0]          word;
    logic [2:0]           map;
  } ev_t;

endpackage

@@ rtl/scs_item_if.sv @@
// input channel of the script call scanner
// no dependencies
interface scs_item_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [2:0]  map_index;
  logic [31:0] script_word;
  logic [3:0]  slot;

  modport source (output valid, output cmd, output map_index, output script_word,
                  output slot, input ready);
  modport sink (input valid, input cmd, input map_index, input script_word,
                input slot, output ready);
endinterface

@@ rtl/scs_result_if.sv @@
// result channel of the script call scanner
// no dependencies
interface scs_result_if;
  logic        valid;
  logic        ready;
  logic        walk_done;
  logic [1:0]  stop_reason;
  logic [13:0] words_walked;
  logic [31:0] read_data;

  modport source (output valid, output walk_done, output stop_reason,
                  output words_walked, output read_data, input ready);
  modport sink (input valid, input walk_done, input stop_reason,
                input words_walked, input read_data, output ready);
endinterface

@@ rtl/scs_walker.sv @@
// walk state: header/argument framing, stop detection, target matching
// depends on scs_pkg
module scs_walker import scs_pkg::*; #(
  parameter int WATCH_SLOTS = 6,
  parameter int MAX_ARGS    = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  item_t       itm,
  input  watch_t      watch_addr,
  input  logic [31:0] control_addr,
  input  logic [12:0] word_limit,
  output ev_t         ev,
  output logic        walk_done,
  output logic [1:0]  stop_reason,
  output logic [13:0] words_walked
);

  localparam int NW = (WATCH_SLOTS < 6) ? WATCH_SLOTS : 6;

  logic        active, active_next;
  logic [1:0]  phase, phase_next;
  logic [13:0] position, position_next;
  logic [4:0]  args_left, args_next;
  logic [4:0]  argc, argc_next;
  logic [2:0]  mslot, mslot_next;
  logic [2:0]  walk_map, map_next;

  logic [15:0]        hdr_argc;
  logic [15:0]        hdr_opc;
  logic [13:0]        end_pos;
  logic [4:0]         args_dec;
  logic [HIT_NUM-1:0] hit;
  logic [2:0]         mslot_hit;
  logic               found;
  logic               end_instr;

  assign hdr_argc = itm.script_word[31:16];
  assign hdr_opc  = itm.script_word[15:0];
  assign end_pos  = position + 14'd1 + {9'd0, (phase == PH_HEADER) ? 5'd0 : argc};
  assign args_dec = (args_left != 5'd0) ? args_left - 5'd1 : 5'd0;

  // first watched match wins, control compared on its own
  always_comb begin
    hit       = '0;
    mslot_hit = NO_SLOT;
    found     = 1'b0;
    for (int i = 0; i < 6; i++) begin
      if (i < NW && !found && itm.script_word == watch_addr[i]) begin
        found  = 1'b1;
        hit[i] = 1'b1;
        if (i < 2) mslot_hit = 3'(i);
      end
    end
    hit[CTRL_IDX] = (itm.script_word == control_addr);
  end

  always_comb begin
    active_next   = active;
    phase_next    = phase;
    position_next = position;
    args_next     = args_left;
    argc_next     = argc;
    mslot_next    = mslot;
    map_next      = walk_map;
    ev            = '0;
    ev.word       = itm.script_word;
    ev.map        = walk_map;
    walk_done     = 1'b0;
    stop_reason   = STOP_END;
    words_walked  = '0;
    end_instr     = 1'b0;
    if (en) begin
      case (itm.cmd)
        CMD_CLEAR: begin
          ev.clear = 1'b1;
        end
        CMD_BEGIN: begin
          active_next   = 1'b1;
          phase_next    = PH_HEADER;
          position_next = '0;
          args_next     = '0;
          argc_next     = '0;
          mslot_next    = NO_SLOT;
          map_next      = itm.map_index;
          ev.begin_walk = 1'b1;
          if (word_limit == 13'd0) begin
            ev.trunc     = 1'b1;
            active_next  = 1'b0;
            walk_done    = 1'b1;
            stop_reason  = STOP_LIMIT;
          end
        end
        CMD_WORD: begin
          if (active) begin
            if (phase == PH_HEADER) begin
              if (hdr_opc == OPC_END) begin
                active_next  = 1'b0;
                mslot_next   = NO_SLOT;
                args_next    = '0;
                walk_done    = 1'b1;
                stop_reason  = STOP_END;
                words_walked = position;
              end else if (hdr_opc > OPC_MAX || hdr_argc > 16'(MAX_ARGS)) begin
                active_next  = 1'b0;
                mslot_next   = NO_SLOT;
                args_next    = '0;
                walk_done    = 1'b1;
                stop_reason  = STOP_DESYNC;
                words_walked = position;
              end else begin
                argc_next  = hdr_argc[4:0];
                args_next  = hdr_argc[4:0];
                mslot_next = NO_SLOT;
                if (hdr_argc[4:0] == 5'd0) begin
                  end_instr = 1'b1;
                end else begin
                  phase_next = (hdr_opc == OPC_CALL) ? PH_TARGET : PH_SKIP;
                end
              end
            end else begin
              if (phase == PH_TARGET) begin
                ev.hit     = hit;
                mslot_next = mslot_hit;
                phase_next = (mslot_hit != NO_SLOT && argc >= 5'd2) ? PH_FIRST : PH_SKIP;
              end else if (phase == PH_FIRST) begin
                ev.cap0    = (mslot == 3'd0);
                ev.cap1    = (mslot == 3'd1);
                mslot_next = NO_SLOT;
                phase_next = PH_SKIP;
              end
              args_next = args_dec;
              if (args_dec == 5'd0) end_instr = 1'b1;
            end
            if (end_instr) begin
              position_next = end_pos;
              phase_next    = PH_HEADER;
              mslot_next    = NO_SLOT;
              args_next     = '0;
              if (end_pos >= {1'b0, word_limit}) begin
                ev.trunc     = 1'b1;
                active_next  = 1'b0;
                walk_done    = 1'b1;
                stop_reason  = STOP_LIMIT;
                words_walked = end_pos;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      phase     <= PH_HEADER;
      position  <= '0;
      args_left <= '0;
      argc      <= '0;
      mslot     <= NO_SLOT;
      walk_map  <= '0;
    end else begin
      active    <= active_next;
      phase     <= phase_next;
      position  <= position_next;
      args_left <= args_next;
      argc      <= argc_next;
      mslot     <= mslot_next;
      walk_map  <= map_next;
    end
  end

endmodule

@@ rtl/scs_report.sv @@
// report counters, first-argument captures and slot read mux
// depends on scs_pkg
module scs_report import scs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  ev_t         ev,
  input  logic [3:0]  slot,
  output logic [31:0] read_data
);

  logic [31:0] hit_counts [HIT_NUM];
  logic [31:0] first_desc_arg;
  logic [31:0] first_map_desc_arg;
  logic [3:0]  capture_map;
  logic [31:0] walks_begun;
  logic [31:0] walks_truncated;

  always_ff @(posedge clk) begin
    if (rst || ev.clear) begin
      for (int i = 0; i < HIT_NUM; i++) hit_counts[i] <= '0;
      first_desc_arg     <= '0;
      first_map_desc_arg <= '0;
      capture_map        <= NO_MAP;
      walks_begun        <= '0;
      walks_truncated    <= '0;
    end else begin
      for (int i = 0; i < HIT_NUM; i++) begin
        if (ev.hit[i]) hit_counts[i] <= hit_counts[i] + 32'd1;
      end
      if (ev.begin_walk) walks_begun <= walks_begun + 32'd1;
      if (ev.trunc) walks_truncated <= walks_truncated + 32'd1;
      if (ev.cap0 && first_desc_arg == 32'd0) first_desc_arg <= ev.word;
      if (ev.cap1 && first_map_desc_arg == 32'd0) begin
        first_map_desc_arg <= ev.word;
        capture_map        <= {1'b0, ev.map};
      end
    end
  end

  always_comb begin
    read_data = '0;
    if (slot <= SLOT_CTRL) begin
      read_data = hit_counts[slot[2:0]];
    end else begin
      case (slot)
        SLOT_CAP0:  read_data = first_desc_arg;
        SLOT_CAP1:  read_data = first_map_desc_arg;
        SLOT_MAP:   read_data = (capture_map == NO_MAP) ? 32'hFFFF_FFFF
                                                        : {28'd0, capture_map};
        SLOT_BEGUN: read_data = walks_begun;
        SLOT_TRUNC: read_data = walks_truncated;
        default:    read_data = '0;
      endcase
    end
  end

endmodule

@@ rtl/script_call_scanner_top.sv @@
// top level of the script call scanner: input register, walker, report, result register
// depends on scs_pkg, scs_item_if, scs_result_if, scs_walker, scs_report
//
// Takes one beat per clock on item, while result.ready stays high, and returns
// exactly one result beat for it. A beat is registered on entry, handled by a single
// pass of compare and counter logic, and lands in the result register;
// throughput is one beat per cycle while result.ready stays high.
// Configuration writes go straight to the registers and must be made while no
// beat is in flight.
module script_call_scanner_top import scs_pkg::*; #(
  parameter int WATCH_SLOTS = 6,
  parameter int MAX_ARGS    = 16
) (
  input  logic               clk,
  input  logic               rst,
  scs_item_if.sink           item,
  scs_result_if.source       result,
  input  logic               cfg_wr_en,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  watch_t      watch_addr;
  logic [31:0] control_addr;
  logic [12:0] word_limit;

  logic        itm_valid;
  item_t       itm;
  logic        advance;

  ev_t         ev;
  logic        done_c;
  logic [1:0]  reason_c;
  logic [13:0] words_c;
  logic [31:0] read_c;

  logic        res_valid;
  logic        res_done;
  logic [1:0]  res_reason;
  logic [13:0] res_words;
  logic [31:0] res_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      watch_addr[0] <= 32'h800E_2610;
      watch_addr[1] <= 32'h800E_4118;
      watch_addr[2] <= 32'h800E_3588;
      watch_addr[3] <= 32'h800E_2908;
      watch_addr[4] <= 32'h800E_45C8;
      watch_addr[5] <= 32'h800E_468C;
      control_addr  <= 32'h800E_B72C;
      word_limit    <= LIMIT_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_CONTROL: control_addr <= cfg_data;
        REG_LIMIT:   word_limit   <= cfg_data[12:0];
        default:     watch_addr[cfg_index] <= cfg_data;
      endcase
    end
  end

  assign advance    = itm_valid && (!res_valid || result.ready);
  assign item.ready = !itm_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      itm_valid <= 1'b0;
    end else if (item.ready) begin
      itm_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      itm.cmd         <= item.cmd;
      itm.map_index   <= item.map_index;
      itm.script_word <= item.script_word;
      itm.slot        <= item.slot;
    end
  end

  scs_walker #(
    .WATCH_SLOTS (WATCH_SLOTS),
    .MAX_ARGS    (MAX_ARGS)
  ) u_walker (
    .clk          (clk),
    .rst          (rst),
    .en           (advance),
    .itm          (itm),
    .watch_addr   (watch_addr),
    .control_addr (control_addr),
    .word_limit   (word_limit),
    .ev           (ev),
    .walk_done    (done_c),
    .stop_reason  (reason_c),
    .words_walked (words_c)
  );

  scs_report u_report (
    .clk       (clk),
    .rst       (rst),
    .ev        (ev),
    .slot      (itm.slot),
    .read_data (read_c)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_done   <= done_c;
      res_reason <= reason_c;
      res_words  <= words_c;
      res_data   <= (itm.cmd == CMD_READ) ? read_c : 32'd0;
    end
  end

  assign result.valid        = res_valid;
  assign result.walk_done    = res_done;
  assign result.stop_reason  = res_reason;
  assign result.words_walked = res_words;
  assign result.read_data    = res_data;

endmodule

@@ test/script_call_scanner_top_tb.sv @@
`timescale 1ns / 1ps
// testbench for script_call_scanner_top: directed and random command streams with random
// idling on both channels, every result beat checked against an in-bench scanner model
// depends on scs_pkg, scs_item_if, scs_result_if and script_call_scanner_top
module script_call_scanner_top_tb;
  import scs_pkg::*;

  localparam int WATCH_SLOTS = 6;
  localparam int MAX_ARGS = 16;
  localparam int MAX_WAIT = 12;
  localparam int STALL_LIMIT = 4000;
  localparam int REPORT_LIMIT = 10;
  localparam logic [2:0] CAP0_SLOT = 3'd0;
  localparam logic [2:0] CAP1_SLOT = 3'd1;
  localparam logic [3:0] SLOT_LAST = 4'd15;

  typedef enum {CFG_DEFAULT, CFG_ALIASED, CFG_EXTREME, CFG_RANDOM} cfg_mode_t;

  typedef struct packed {
    logic        walk_done;
    logic [1:0]  stop_reason;
    logic [13:0] words_walked;
    logic [31:0] read_data;
  } walk_res_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_wr_en;
  logic [2:0] cfg_index;
  logic [31:0] cfg_data;
  logic sink_ready = 1'b0;

  scs_item_if item();
  scs_result_if result();

  assign result.ready = sink_ready;

  script_call_scanner_top #(
    .WATCH_SLOTS(WATCH_SLOTS),
    .MAX_ARGS(MAX_ARGS)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .item(item),
    .result(result),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // scanner model state
  logic [31:0] watch_addr [6];
  logic [31:0] ctrl_addr;
  logic [12:0] word_limit;
  logic walking;
  logic [1:0] walk_phase;
  logic [13:0] pos;
  logic [4:0] args_left;
  logic [4:0] cur_argc;
  logic [2:0] call_slot;
  logic [2:0] walk_map;
  logic [31:0] hit_cnt [HIT_NUM];
  logic [31:0] cap_arg0;
  logic [31:0] cap_arg1;
  logic [3:0] cap_map;
  logic [31:0] walks_begun;
  logic [31:0] walks_cut;

  walk_res_t walk_results_due [$];
  walk_res_t mon_got;
  walk_res_t mon_want;
  int useful_beats = 0;
  int mismatch_count = 0;
  int idle_cycles = 0;
  int sink_wait = 0;
  int sink_draw;
  bit src_burst = 1'b0;
  bit sink_burst = 1'b0;

  function automatic void clear_counts();
    for (int i = 0; i < HIT_NUM; i++) hit_cnt[i] = '0;
    cap_arg0 = '0;
    cap_arg1 = '0;
    cap_map = NO_MAP;
    walks_begun = '0;
    walks_cut = '0;
  endfunction

  function automatic void reset_model();
    watch_addr[0] = 32'h800E2610;
    watch_addr[1] = 32'h800E4118;
    watch_addr[2] = 32'h800E3588;
    watch_addr[3] = 32'h800E2908;
    watch_addr[4] = 32'h800E45C8;
    watch_addr[5] = 32'h800E468C;
    ctrl_addr = 32'h800EB72C;
    word_limit = LIMIT_RESET;
    walking = 1'b0;
    walk_phase = PH_HEADER;
    pos = '0;
    args_left = '0;
    cur_argc = '0;
    call_slot = NO_SLOT;
    walk_map = '0;
    clear_counts();
  endfunction

  function automatic void stop_walk(inout walk_res_t r, input logic [1:0] why);
    walking = 1'b0;
    walk_phase = PH_HEADER;
    call_slot = NO_SLOT;
    args_left = '0;
    r.walk_done = 1'b1;
    r.stop_reason = why;
    r.words_walked = pos;
  endfunction

  function automatic void check_limit(inout walk_res_t r);
    if (pos >= word_limit) begin
      walks_cut++;
      stop_walk(r, STOP_LIMIT);
    end
  endfunction

  function automatic void next_instruction(inout walk_res_t r);
    pos = pos + 14'd1 + cur_argc;
    walk_phase = PH_HEADER;
    call_slot = NO_SLOT;
    args_left = '0;
    check_limit(r);
  endfunction

  function automatic void match_call(input logic [31:0] tgt);
    bit found;
    found = 1'b0;
    call_slot = NO_SLOT;
    for (int i = 0; i < WATCH_SLOTS && i < 6; i++) begin
      if (!found && tgt == watch_addr[i]) begin
        found = 1'b1;
        hit_cnt[i]++;
        if (i < 2) call_slot = 3'(i);
      end
    end
    if (tgt == ctrl_addr) hit_cnt[CTRL_IDX]++;
  endfunction

  function automatic void take_word(input logic [31:0] w, inout walk_res_t r);
    logic [15:0] opc;
    logic [15:0] cnt;
    opc = w[15:0];
    cnt = w[31:16];
    if (walk_phase == PH_HEADER) begin
      if (opc == OPC_END) begin
        stop_walk(r, STOP_END);
      end else if (opc > OPC_MAX || cnt > MAX_ARGS) begin
        stop_walk(r, STOP_DESYNC);
      end else begin
        cur_argc = cnt[4:0];
        args_left = cur_argc;
        call_slot = NO_SLOT;
        if (cur_argc == '0) next_instruction(r);
        else walk_phase = (opc == OPC_CALL) ? PH_TARGET : PH_SKIP;
      end
    end else begin
      if (walk_phase == PH_TARGET) begin
        match_call(w);
        walk_phase = (call_slot != NO_SLOT && cur_argc >= 5'd2) ? PH_FIRST : PH_SKIP;
      end else if (walk_phase == PH_FIRST) begin
        if (call_slot == CAP0_SLOT && cap_arg0 == '0) cap_arg0 = w;
        if (call_slot == CAP1_SLOT && cap_arg1 == '0) begin
          cap_arg1 = w;
          cap_map = {1'b0, walk_map};
        end
        call_slot = NO_SLOT;
        walk_phase = PH_SKIP;
      end
      if (args_left > '0) args_left--;
      if (args_left == '0) next_instruction(r);
    end
  endfunction

  function automatic logic [31:0] slot_value(input logic [3:0] s);
    if (s <= SLOT_CTRL) return hit_cnt[s];
    case (s)
      SLOT_CAP0: return cap_arg0;
      SLOT_CAP1: return cap_arg1;
      SLOT_MAP: return (cap_map == NO_MAP) ? 32'hFFFF_FFFF : {28'd0, cap_map};
      SLOT_BEGUN: return walks_begun;
      SLOT_TRUNC: return walks_cut;
      default: return '0;
    endcase
  endfunction

  function automatic walk_res_t walk_step(input item_t it);
    walk_res_t r;
    r = '0;
    case (it.cmd)
      CMD_CLEAR: clear_counts();
      CMD_BEGIN: begin
        walking = 1'b1;
        walk_phase = PH_HEADER;
        pos = '0;
        args_left = '0;
        cur_argc = '0;
        call_slot = NO_SLOT;
        walk_map = it.map_index;
        walks_begun++;
        check_limit(r);
      end
      CMD_WORD: if (walking) take_word(it.script_word, r);
      default: r.read_data = slot_value(it.slot);
    endcase
    return r;
  endfunction

  function automatic logic [31:0] header_word(input logic [15:0] opc, input logic [15:0] cnt);
    return {cnt, opc};
  endfunction

  function automatic item_t rand_item(input logic [1:0] cmd);
    item_t it;
    it.cmd = cmd;
    it.map_index = 3'($urandom_range(7, 0));
    it.script_word = $urandom;
    it.slot = 4'($urandom_range(15, 0));
    return it;
  endfunction

  function automatic logic [31:0] pick_target();
    int k;
    k = $urandom_range(8, 0);
    if (k < 6) return watch_addr[k];
    if (k < 8) return ctrl_addr;
    return $urandom;
  endfunction

  task automatic send_item(input item_t it);
    int gap;
    if ($urandom_range(31, 0) == 0) src_burst = !src_burst;
    gap = src_burst ? 0 : $urandom_range(MAX_WAIT, 0);
    if (gap > 0) begin
      item.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item.valid <= 1'b1;
    item.cmd <= it.cmd;
    item.map_index <= it.map_index;
    item.script_word <= it.script_word;
    item.slot <= it.slot;
    do @(posedge clk); while (item.ready !== 1'b1);
    if (!(it.cmd == CMD_WORD && !walking)) useful_beats++;
    walk_results_due.push_back(walk_step(it));
  endtask

  task automatic do_word(input logic [31:0] w);
    item_t it;
    it = rand_item(CMD_WORD);
    it.script_word = w;
    send_item(it);
  endtask

  task automatic do_begin(input logic [2:0] m);
    item_t it;
    it = rand_item(CMD_BEGIN);
    it.map_index = m;
    send_item(it);
  endtask

  task automatic do_read(input logic [3:0] s);
    item_t it;
    it = rand_item(CMD_READ);
    it.slot = s;
    send_item(it);
  endtask

  task automatic do_clear();
    send_item(rand_item(CMD_CLEAR));
  endtask

  task automatic send_noise();
    int k;
    k = $urandom_range(15, 0);
    if (k == 0) send_item(rand_item(CMD_CLEAR));
    else if (k < 3) send_item(rand_item(CMD_BEGIN));
    else if (k < 7) send_item(rand_item(CMD_WORD));
    else send_item(rand_item(CMD_READ));
  endtask

  task automatic drain();
    item.valid <= 1'b0;
    while (walk_results_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_CONTROL: ctrl_addr = data;
      REG_LIMIT: word_limit = data[12:0];
      default: watch_addr[idx] = data;
    endcase
  endtask

  task automatic run_walk();
    int n;
    int cnt;
    logic [15:0] opc;
    do_begin(3'($urandom_range(7, 0)));
    n = $urandom_range(24, 1);
    for (int k = 0; k < n && walking; k++) begin
      if ($urandom_range(11, 0) == 0) send_noise();
      if ($urandom_range(39, 0) == 0) begin
        do_word($urandom);
        continue;
      end
      opc = ($urandom_range(1, 0) == 0) ? OPC_CALL : 16'($urandom_range(OPC_MAX, 0));
      if (opc == OPC_END) opc = OPC_CALL;
      cnt = ($urandom_range(5, 0) == 0) ? $urandom_range(MAX_ARGS, 0) : $urandom_range(3, 0);
      if (opc == OPC_CALL && cnt == 0 && $urandom_range(1, 0) == 1) cnt = 2;
      do_word(header_word(opc, 16'(cnt)));
      for (int a = 0; a < cnt && walking; a++) begin
        if (a == 0 && opc == OPC_CALL) do_word(pick_target());
        else if (a == 1 && $urandom_range(3, 0) == 0) do_word('0);
        else do_word($urandom);
      end
    end
    if (walking) begin
      case ($urandom_range(7, 0))
        0: do_word(header_word(16'($urandom_range(16'hFFFF, OPC_MAX + 1)), 16'($urandom)));
        1: do_word(header_word(OPC_CALL, 16'($urandom_range(16'hFFFF, MAX_ARGS + 1))));
        2: ;
        default: do_word(header_word(OPC_END, 16'($urandom)));
      endcase
    end
    if ($urandom_range(2, 0) == 0) do_read(4'($urandom_range(11, 0)));
  endtask

  task automatic test_idle_stream();
    do_word($urandom);
    do_read(SLOT_MAP);
    do_read(SLOT_LAST);
  endtask

  task automatic test_captures();
    do_begin(3'd5);
    do_word(header_word(OPC_CALL, 16'd1));
    do_word(watch_addr[0]);
    do_word(header_word(OPC_CALL, 16'd3));
    do_word(watch_addr[0]);
    do_word('0);
    do_word($urandom);
    do_word(header_word(OPC_CALL, 16'd2));
    do_word(watch_addr[0]);
    do_word(32'h1234_5678);
    do_word(header_word(OPC_CALL, 16'd3));
    do_word(watch_addr[1]);
    do_word('0);
    // new walk while the last call still has an argument to come
    do_begin(3'd2);
    do_word(header_word(OPC_CALL, 16'd2));
    do_word(watch_addr[1]);
    do_word(32'hFFFF_FFFF);
    do_word(header_word(OPC_END, 16'hFFFF));
    do_read(SLOT_CAP0);
    do_read(SLOT_CAP1);
    do_read(SLOT_MAP);
  endtask

  task automatic test_stops();
    do_begin(3'd7);
    do_word(header_word(OPC_MAX, 16'd0));
    do_word(header_word(OPC_MAX + 16'd1, 16'd0));
    do_begin(3'd0);
    do_word(header_word(16'h0000, 16'(MAX_ARGS + 1)));
    do_word($urandom);
  endtask

  task automatic test_word_limit();
    drain();
    write_reg(REG_LIMIT, '0);
    do_begin(3'd1);
    drain();
    write_reg(REG_LIMIT, 32'd1);
    do_begin(3'd3);
    do_word(header_word(16'h0010, 16'd0));
    do_read(SLOT_TRUNC);
    do_clear();
    do_read(SLOT_BEGUN);
  endtask

  task automatic test_random_walks(input cfg_mode_t mode, input int goal);
    int target;
    logic [31:0] w [6];
    drain();
    for (int i = 0; i < 6; i++) w[i] = $urandom;
    case (mode)
      CFG_DEFAULT: write_reg(REG_LIMIT, 32'($urandom_range(300, 40)));
      CFG_ALIASED: begin
        w[2] = w[0];
        w[5] = w[1];
        for (int i = 0; i < 6; i++) write_reg(3'(i), w[i]);
        write_reg(REG_CONTROL, w[1]);
        write_reg(REG_LIMIT, 32'd8191);
      end
      CFG_EXTREME: begin
        w[0] = '0;
        w[1] = 32'hFFFF_FFFF;
        for (int i = 0; i < 6; i++) write_reg(3'(i), w[i]);
        write_reg(REG_CONTROL, '0);
        write_reg(REG_LIMIT, 32'($urandom_range(12, 1)));
      end
      default: begin
        for (int i = 0; i < 6; i++) write_reg(3'(i), w[i]);
        write_reg(REG_CONTROL, $urandom);
        write_reg(REG_LIMIT, 32'($urandom_range(400, 1)));
      end
    endcase
    target = useful_beats + goal;
    while (useful_beats < target) begin
      if ($urandom_range(7, 0) == 0) send_noise();
      else run_walk();
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      sink_ready <= 1'b0;
      sink_wait <= 0;
    end else if (sink_wait > 0) begin
      sink_wait <= sink_wait - 1;
    end else if (sink_ready && result.valid === 1'b1) begin
      if ($urandom_range(31, 0) == 0) sink_burst = !sink_burst;
      sink_draw = sink_burst ? 0 : $urandom_range(MAX_WAIT, 0);
      sink_ready <= (sink_draw == 0);
      sink_wait <= (sink_draw > 0) ? sink_draw - 1 : 0;
    end else begin
      sink_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (result.valid === 1'b1 && sink_ready) begin
        mon_got = {result.walk_done, result.stop_reason, result.words_walked, result.read_data};
        if (walk_results_due.size() == 0) begin
          if (mismatch_count < REPORT_LIMIT)
            $display("unexpected result beat: done=%0d reason=%0d words=%0d data=%h",
                     mon_got.walk_done, mon_got.stop_reason, mon_got.words_walked,
                     mon_got.read_data);
          mismatch_count++;
        end else begin
          mon_want = walk_results_due.pop_front();
          if (mon_got !== mon_want) begin
            if (mismatch_count < REPORT_LIMIT)
              $display("mismatch: expected done=%0d reason=%0d words=%0d data=%h, %s%0d%s%0d%s%0d%s%h",
                       mon_want.walk_done, mon_want.stop_reason, mon_want.words_walked,
                       mon_want.read_data, "got done=", mon_got.walk_done,
                       " reason=", mon_got.stop_reason, " words=", mon_got.words_walked,
                       " data=", mon_got.read_data);
            mismatch_count++;
          end
        end
      end
      if ((item.valid === 1'b1 && item.ready === 1'b1) ||
          (result.valid === 1'b1 && sink_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("[script_call_scanner_top] ERROR");
        $finish;
      end
    end
  end

  initial begin
    rst <= 1'b1;
    cfg_wr_en <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    item.valid <= 1'b0;
    item.cmd <= CMD_CLEAR;
    item.map_index <= '0;
    item.script_word <= '0;
    item.slot <= '0;
    reset_model();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_idle_stream();
    test_captures();
    test_stops();
    test_word_limit();
    test_random_walks(CFG_DEFAULT, 350);
    test_random_walks(CFG_ALIASED, 350);
    test_random_walks(CFG_EXTREME, 300);
    test_random_walks(CFG_RANDOM, 400);
    drain();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[script_call_scanner_top] OK");
    end else begin
      $display("[script_call_scanner_top] ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/scs_pkg.sv
rtl/scs_item_if.sv
rtl/scs_result_if.sv
rtl/scs_walker.sv
rtl/scs_report.sv
rtl/script_call_scanner_top.sv
test/script_call_scanner_top_tb.sv
